FILE: design/sngs_pkg.sv
// Shared types and constants for the sequencer note gate scheduler.
// No dependencies; imported by sequencer_note_gate_scheduler.
`timescale 1ns / 1ps

package sngs_pkg;

   // Default sizes of the slot table and the gate length limit.
   localparam int TRACKS_DEF     = 16;
   localparam int VOICES_DEF     = 4;
   localparam int MAX_LENGTH_DEF = 64;

   // Largest note number and velocity.
   localparam logic [6:0] NOTE_MAX = 7'd127;

   // Event kinds on the result channel.
   localparam logic EV_NOTE_OFF = 1'b0;
   localparam logic EV_NOTE_ON  = 1'b1;

   // One input transaction as held in the work stage.
   typedef struct packed {
      logic [3:0]        track;
      logic [1:0]        voice_slot;
      logic [31:0]       cur_step;
      logic              muted;
      logic              trigger_enabled;
      logic              voice_on;
      logic [6:0]        note;
      logic [6:0]        velocity;
      logic [7:0]        length;
      logic signed [7:0] transpose_offset;
      logic signed [7:0] velocity_offset;
      logic signed [7:0] length_offset;
   } req_type;

   // One entry of the sounding note table.
   typedef struct packed {
      logic [6:0]  note;
      logic [31:0] release_step;
   } slot_type;

endpackage

FILE: design/sequencer_note_gate_scheduler.sv
// A transaction is held in the work stage; its events are offered from the result register.
// Throughput: one transaction per cycle while each yields at most one event and the result
// channel does not stall; a transaction that cuts a note and starts a new one holds the
// work stage until its note-off and then its note-on have entered the result register.
// Reset clears the valid flags and the per-slot gate flags; the note table needs no
// clearing pass, since an entry is used only while its gate is set. Needs sngs_pkg.
`timescale 1ns / 1ps

module sequencer_note_gate_scheduler
   import sngs_pkg::*;
#(
   parameter int TRACKS     = TRACKS_DEF,
   parameter int VOICES     = VOICES_DEF,
   parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_ready,
   input  logic [3:0]        req_track,
   input  logic [1:0]        req_voice_slot,
   input  logic [31:0]       req_cur_step,
   input  logic              req_muted,
   input  logic              req_trigger_enabled,
   input  logic              req_voice_on,
   input  logic [6:0]        req_note,
   input  logic [6:0]        req_velocity,
   input  logic [7:0]        req_length,
   input  logic signed [7:0] req_transpose_offset,
   input  logic signed [7:0] req_velocity_offset,
   input  logic signed [7:0] req_length_offset,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_is_note_on,
   output logic [3:0]        rsp_out_track,
   output logic [6:0]        rsp_out_note,
   output logic [6:0]        rsp_out_velocity,
   output logic              rsp_last
);

   localparam int SLOTS = TRACKS * VOICES;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // Work stage and result register.
   req_type    s1_ff;
   logic       s1_vld_ff;
   logic       phase_ff;
   logic       phase_in;
   slot_type   rd_ff;
   logic       gate_active_ff [SLOTS];
   slot_type   table_mem [SLOTS];

   logic       rsp_valid_ff;
   logic       rsp_is_note_on_ff;
   logic [3:0] rsp_out_track_ff;
   logic [6:0] rsp_out_note_ff;
   logic [6:0] rsp_out_velocity_ff;
   logic       rsp_last_ff;

   logic              req_accept;
   logic [6:0]        req_idx_full;
   logic [IDX_W-1:0]  req_idx;
   logic [6:0]        s1_idx_full;
   logic [IDX_W-1:0]  s1_idx;
   logic              in_range;
   logic              active;
   logic              expired;
   logic signed [8:0] vel_sum;
   logic signed [8:0] nt_sum;
   logic [7:0]        len_base;
   logic signed [9:0] len_sum;
   logic [6:0]        vel_clamp;
   logic [6:0]        nt_clamp;
   logic [7:0]        len_clamp;
   logic              on_ev;
   logic              off_ev;
   logic              out_free;
   logic              push;
   logic              done;
   logic              commit;
   logic              ev_last;
   logic              ev_is_on;
   slot_type          wr_data;

   // Slot index of the incoming and the held transaction.
   assign req_idx_full = 7'(req_track) * 7'(VOICES) + 7'(req_voice_slot);
   assign req_idx      = req_idx_full[IDX_W-1:0];
   assign s1_idx_full  = 7'(s1_ff.track) * 7'(VOICES) + 7'(s1_ff.voice_slot);
   assign s1_idx       = s1_idx_full[IDX_W-1:0];

   // Offsets and clamps for a triggered voice.
   always_comb begin
      vel_sum  = $signed({2'b00, s1_ff.velocity}) +
                 $signed({s1_ff.velocity_offset[7], s1_ff.velocity_offset});
      nt_sum   = $signed({2'b00, s1_ff.note}) +
                 $signed({s1_ff.transpose_offset[7], s1_ff.transpose_offset});
      len_base = (s1_ff.length == 8'd0) ? 8'd1 : s1_ff.length;
      len_sum  = $signed({2'b00, len_base}) +
                 $signed({{2{s1_ff.length_offset[7]}}, s1_ff.length_offset});

      if (vel_sum > $signed({2'b00, NOTE_MAX})) begin
         vel_clamp = NOTE_MAX;
      end else begin
         vel_clamp = vel_sum[6:0];
      end

      if (nt_sum < 9'sd0) begin
         nt_clamp = 7'd0;
      end else if (nt_sum > $signed({2'b00, NOTE_MAX})) begin
         nt_clamp = NOTE_MAX;
      end else begin
         nt_clamp = nt_sum[6:0];
      end

      if (len_sum < 10'sd1) begin
         len_clamp = 8'd1;
      end else if (len_sum > $signed(10'(MAX_LENGTH))) begin
         len_clamp = 8'(MAX_LENGTH);
      end else begin
         len_clamp = len_sum[7:0];
      end
   end

   // Event decision: at most one note-off followed by at most one note-on.
   always_comb begin
      in_range = ({1'b0, s1_ff.track} < 5'(TRACKS)) &&
                 ({2'b00, s1_ff.voice_slot} < 4'(VOICES));
      active   = gate_active_ff[s1_idx];
      expired  = s1_ff.cur_step >= rd_ff.release_step;
      on_ev    = in_range && !s1_ff.muted && s1_ff.trigger_enabled &&
                 s1_ff.voice_on && (vel_sum > 9'sd0);
      off_ev   = in_range && active && (expired || s1_ff.muted || on_ev);
      wr_data.note         = nt_clamp;
      wr_data.release_step = s1_ff.cur_step + 32'(len_clamp);
   end

   // Sequencing of the events of the held transaction into the result register.
   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      ev_is_on = phase_ff || !off_ev;
      ev_last  = phase_ff || !(off_ev && on_ev);
      push     = 1'b0;
      done     = 1'b0;
      if (s1_vld_ff) begin
         if (!off_ev && !on_ev) begin
            done = 1'b1;
         end else if (out_free) begin
            push = 1'b1;
            done = ev_last;
         end
      end
      phase_in   = push && !done;
      commit     = s1_vld_ff && done;
      req_ready  = !s1_vld_ff || done;
      req_accept = req_valid && req_ready;
   end

   // Work stage registers and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            s1_vld_ff <= 1'b1;
         end else if (done) begin
            s1_vld_ff <= 1'b0;
         end
         if (push || done) begin
            phase_ff <= phase_in;
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (req_accept) begin
         s1_ff.track            <= req_track;
         s1_ff.voice_slot       <= req_voice_slot;
         s1_ff.cur_step         <= req_cur_step;
         s1_ff.muted            <= req_muted;
         s1_ff.trigger_enabled  <= req_trigger_enabled;
         s1_ff.voice_on         <= req_voice_on;
         s1_ff.note             <= req_note;
         s1_ff.velocity         <= req_velocity;
         s1_ff.length           <= req_length;
         s1_ff.transpose_offset <= req_transpose_offset;
         s1_ff.velocity_offset  <= req_velocity_offset;
         s1_ff.length_offset    <= req_length_offset;
      end

      if (push) begin
         rsp_is_note_on_ff   <= ev_is_on ? EV_NOTE_ON : EV_NOTE_OFF;
         rsp_out_track_ff    <= s1_ff.track;
         rsp_out_note_ff     <= ev_is_on ? nt_clamp : rd_ff.note;
         rsp_out_velocity_ff <= ev_is_on ? vel_clamp : 7'd0;
         rsp_last_ff         <= ev_last;
      end
   end

   // Per-slot gate flags; these also mark which table entries hold live data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            gate_active_ff[i] <= 1'b0;
         end
      end else if (commit) begin
         if (on_ev) begin
            gate_active_ff[s1_idx] <= 1'b1;
         end else if (off_ev) begin
            gate_active_ff[s1_idx] <= 1'b0;
         end
      end
   end

   // Note table: written when a note starts, read as a transaction is accepted.
   // A write in the same cycle to the same slot is passed straight to the read register.
   always_ff @(posedge clock) begin
      if (commit && on_ev) begin
         table_mem[s1_idx] <= wr_data;
      end
      if (req_accept) begin
         if (commit && on_ev && (s1_idx == req_idx)) begin
            rd_ff <= wr_data;
         end else begin
            rd_ff <= table_mem[req_idx];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_note_on   = rsp_is_note_on_ff;
   assign rsp_out_track    = rsp_out_track_ff;
   assign rsp_out_note     = rsp_out_note_ff;
   assign rsp_out_velocity = rsp_out_velocity_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTH
   // A note-off always carries zero velocity.
   a_off_zero_vel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_is_note_on == EV_NOTE_OFF)) |-> (rsp_out_velocity == 7'd0))
      else $error("note-off with nonzero velocity");

   // A note-on never carries zero velocity.
   a_on_nonzero_vel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_is_note_on == EV_NOTE_ON)) |-> (rsp_out_velocity != 7'd0))
      else $error("note-on with zero velocity");

   // The first of two events from one transaction is always the cutting note-off.
   a_first_is_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_is_note_on == EV_NOTE_OFF))
      else $error("non-final event is not a note-off");

   // The second phase only exists while a transaction is held.
   a_phase_held: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> s1_vld_ff)
      else $error("second event pending without a held transaction");

   // A started note leaves its gate flag set.
   a_gate_set: assert property (@(posedge clock) disable iff (reset)
      (commit && on_ev) |=> gate_active_ff[$past(s1_idx)])
      else $error("gate flag not set after note-on");
`endif

endmodule

FILE: dv/sngs_gate_checker.sv
// Checker for the sequencer note gate scheduler: watches both channels, predicts
// the note events of each accepted transaction and compares them in order.
// Depends on sngs_pkg.
`timescale 1ns / 1ps

module sngs_gate_checker
   import sngs_pkg::*;
#(
   parameter int TRACKS     = TRACKS_DEF,
   parameter int VOICES     = VOICES_DEF,
   parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   input  logic       req_ready,
   input  req_type    req_item,

   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_is_note_on,
   input  logic [3:0] rsp_out_track,
   input  logic [6:0] rsp_out_note,
   input  logic [6:0] rsp_out_velocity,
   input  logic       rsp_last,

   output int         mismatch_total,
   output int         events_outstanding
);

   localparam int SLOTS      = TRACKS * VOICES;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic       is_note_on;
      logic [3:0] track;
      logic [6:0] note;
      logic [6:0] velocity;
      logic       last;
   } gate_event_type;

   // Mirror of the sounding note table.
   logic        gate_on   [SLOTS];
   logic [6:0]  held_note [SLOTS];
   logic [31:0] release_at[SLOTS];

   gate_event_type expected_events[$];
   int             mismatches = 0;

   function automatic gate_event_type make_event(logic on, logic [3:0] trk, logic [6:0] nt,
                                                 logic [6:0] vel);
      gate_event_type ev;
      ev.is_note_on = on;
      ev.track      = trk;
      ev.note       = nt;
      ev.velocity   = vel;
      ev.last       = 1'b0;
      return ev;
   endfunction

   task automatic free_slot(int slot);
      gate_on[slot]    = 1'b0;
      held_note[slot]  = 7'd0;
      release_at[slot] = 32'd0;
   endtask

   // Works out the note events of one transaction and updates the table mirror.
   task automatic predict_gate_events(input req_type item);
      gate_event_type produced[2];
      int             count;
      int             slot;
      int             vel_sum;
      int             note_sum;
      int             len_sum;
      count = 0;
      if (item.track < TRACKS && item.voice_slot < VOICES) begin
         slot = int'(item.track) * VOICES + int'(item.voice_slot);

         // A note whose release step has been reached is released first.
         if (gate_on[slot] && item.cur_step >= release_at[slot]) begin
            produced[count] = make_event(EV_NOTE_OFF, item.track, held_note[slot], 7'd0);
            count++;
            free_slot(slot);
         end

         if (item.muted) begin
            // Mute cuts whatever still sounds and suppresses any trigger.
            if (gate_on[slot]) begin
               produced[count] = make_event(EV_NOTE_OFF, item.track, held_note[slot], 7'd0);
               count++;
               free_slot(slot);
            end
         end else if (item.trigger_enabled && item.voice_on) begin
            vel_sum = int'(item.velocity) + int'($signed(item.velocity_offset));
            if (vel_sum > 0) begin
               note_sum = int'(item.note) + int'($signed(item.transpose_offset));
               len_sum  = ((item.length == 8'd0) ? 1 : int'(item.length)) +
                          int'($signed(item.length_offset));
               if (vel_sum > int'(NOTE_MAX)) vel_sum = int'(NOTE_MAX);
               if (note_sum < 0) note_sum = 0;
               else if (note_sum > int'(NOTE_MAX)) note_sum = int'(NOTE_MAX);
               if (len_sum < 1) len_sum = 1;
               else if (len_sum > MAX_LENGTH) len_sum = MAX_LENGTH;

               // An old note still held in the slot is cut before the new one.
               if (gate_on[slot]) begin
                  produced[count] = make_event(EV_NOTE_OFF, item.track, held_note[slot],
                                               7'd0);
                  count++;
                  free_slot(slot);
               end
               produced[count] = make_event(EV_NOTE_ON, item.track, 7'(note_sum),
                                            7'(vel_sum));
               count++;
               gate_on[slot]    = 1'b1;
               held_note[slot]  = 7'(note_sum);
               release_at[slot] = item.cur_step + 32'(len_sum);
            end
         end
      end

      for (int i = 0; i < count; i++) begin
         if (i == count - 1) produced[i].last = 1'b1;
         expected_events.push_back(produced[i]);
      end
   endtask

   // Predict on each accepted request, then compare each accepted result.
   always @(posedge clock) begin : watch
      gate_event_type seen;
      gate_event_type want;
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) free_slot(s);
         expected_events.delete();
      end else begin
         if (req_valid && req_ready) predict_gate_events(req_item);

         if (rsp_valid && rsp_ready) begin
            seen.is_note_on = rsp_is_note_on;
            seen.track      = rsp_out_track;
            seen.note       = rsp_out_note;
            seen.velocity   = rsp_out_velocity;
            seen.last       = rsp_last;
            if (expected_events.size() == 0) begin
               if (mismatches < REPORT_MAX)
                  $display("%0t: unexpected event on=%0d track=%0d note=%0d vel=%0d last=%0d",
                           $time, seen.is_note_on, seen.track, seen.note, seen.velocity,
                           seen.last);
               mismatches++;
            end else begin
               want = expected_events.pop_front();
               if (seen !== want) begin
                  if (mismatches < REPORT_MAX)
                     $display({"%0t: event mismatch: expected on=%0d track=%0d note=%0d ",
                               "vel=%0d last=%0d, got on=%0d track=%0d note=%0d vel=%0d ",
                               "last=%0d"},
                              $time, want.is_note_on, want.track, want.note, want.velocity,
                              want.last, seen.is_note_on, seen.track, seen.note,
                              seen.velocity, seen.last);
                  mismatches++;
               end
            end
         end
      end
      events_outstanding <= expected_events.size();
      mismatch_total     <= mismatches;
   end

endmodule

FILE: dv/tb_sequencer_note_gate_scheduler.sv
// Testbench top for the sequencer note gate scheduler: drives directed and random
// voice transactions with random idling on both channels and gives the verdict.
// Depends on sngs_pkg, sngs_gate_checker and sequencer_note_gate_scheduler.
`timescale 1ns / 1ps

module tb_sequencer_note_gate_scheduler;
   import sngs_pkg::*;

   localparam int GAP_MAX      = 13;
   localparam int RANDOM_ITEMS = 1100;
   localparam int IDLE_LIMIT   = 2000;
   localparam int TAIL_CYCLES  = 20;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   req_type    req_item;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_is_note_on;
   logic [3:0] rsp_out_track;
   logic [6:0] rsp_out_note;
   logic [6:0] rsp_out_velocity;
   logic       rsp_last;

   int          mismatch_total;
   int          events_outstanding;
   int          idle_cycles = 0;
   int          send_calm   = 0;
   int          recv_calm   = 0;
   logic [31:0] song_step;

   always #2 clock = ~clock;

   sequencer_note_gate_scheduler dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_track            (req_item.track),
      .req_voice_slot       (req_item.voice_slot),
      .req_cur_step         (req_item.cur_step),
      .req_muted            (req_item.muted),
      .req_trigger_enabled  (req_item.trigger_enabled),
      .req_voice_on         (req_item.voice_on),
      .req_note             (req_item.note),
      .req_velocity         (req_item.velocity),
      .req_length           (req_item.length),
      .req_transpose_offset (req_item.transpose_offset),
      .req_velocity_offset  (req_item.velocity_offset),
      .req_length_offset    (req_item.length_offset),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_is_note_on       (rsp_is_note_on),
      .rsp_out_track        (rsp_out_track),
      .rsp_out_note         (rsp_out_note),
      .rsp_out_velocity     (rsp_out_velocity),
      .rsp_last             (rsp_last)
   );

   sngs_gate_checker gate_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_item           (req_item),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_is_note_on     (rsp_is_note_on),
      .rsp_out_track      (rsp_out_track),
      .rsp_out_note       (rsp_out_note),
      .rsp_out_velocity   (rsp_out_velocity),
      .rsp_last           (rsp_last),
      .mismatch_total     (mismatch_total),
      .events_outstanding (events_outstanding)
   );

   // Idle cycles before the next transaction; calm stretches bring no idling.
   function automatic int pick_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 50);
      return $urandom_range(0, GAP_MAX);
   endfunction

   function automatic req_type voice_item(logic [3:0] trk, logic [1:0] slot,
                                          logic [31:0] step, logic mute, logic trig,
                                          logic von, logic [6:0] nt, logic [6:0] vel,
                                          logic [7:0] len, logic signed [7:0] tofs,
                                          logic signed [7:0] vofs, logic signed [7:0] lofs);
      req_type item;
      item.track            = trk;
      item.voice_slot       = slot;
      item.cur_step         = step;
      item.muted            = mute;
      item.trigger_enabled  = trig;
      item.voice_on         = von;
      item.note             = nt;
      item.velocity         = vel;
      item.length           = len;
      item.transpose_offset = tofs;
      item.velocity_offset  = vofs;
      item.length_offset    = lofs;
      return item;
   endfunction

   // Offers one transaction after a random gap and holds it until accepted.
   task automatic send_item(input req_type item);
      int gap;
      gap = pick_gap(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // Holds the sender off until every predicted event has come out.
   task automatic drain_events();
      req_valid <= 1'b0;
      @(posedge clock);
      while (events_outstanding != 0) @(posedge clock);
   endtask

   // Result side: random stalls between events.
   initial begin : receiver
      int stall;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = pick_gap(recv_calm);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Watchdog: ends the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      req_type     item;
      logic [95:0] noise;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_item  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A plain note, then a retrigger that cuts it before the new note.
      send_item(voice_item(0, 0, 32'd100, 0, 1, 1, 60, 100, 4, 0, 0, 0));
      send_item(voice_item(0, 0, 32'd102, 0, 1, 1, 62, 90, 2, 0, 0, 0));
      // Release exactly at the release step with no new trigger.
      send_item(voice_item(0, 0, 32'd104, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // Velocities that do not end above zero drop the voice.
      send_item(voice_item(0, 1, 32'd110, 0, 1, 1, 64, 0, 4, 0, 0, 0));
      send_item(voice_item(0, 1, 32'd110, 0, 1, 1, 64, 10, 4, 0, -10, 0));
      send_item(voice_item(0, 1, 32'd110, 0, 1, 1, 64, 127, 4, 0, -128, 0));
      // Upper clamps on velocity, note and length on the last track and slot.
      send_item(voice_item(15, 3, 32'd200, 0, 1, 1, 127, 127, 255, 127, 127, 127));
      // Lower clamps on note and length; a zero length counts as one step.
      send_item(voice_item(1, 2, 32'd300, 0, 1, 1, 0, 1, 0, -128, 0, -128));
      send_item(voice_item(1, 3, 32'd300, 0, 1, 1, 5, 1, 0, 0, 0, 0));
      // Expiry and a new trigger in the same transaction.
      send_item(voice_item(1, 2, 32'd301, 0, 1, 1, 70, 50, 3, 0, 0, 0));
      // Mute cuts a sounding note and wins over a trigger.
      send_item(voice_item(15, 3, 32'd201, 1, 1, 1, 40, 40, 4, 0, 0, 0));
      // Mute with nothing sounding.
      send_item(voice_item(15, 3, 32'd202, 1, 1, 1, 40, 40, 4, 0, 0, 0));
      // Expired and muted together yield a single note-off.
      send_item(voice_item(1, 3, 32'd400, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      // Trigger without the voice, and the voice without a trigger.
      send_item(voice_item(1, 2, 32'd302, 0, 1, 0, 20, 20, 2, 0, 0, 0));
      send_item(voice_item(1, 2, 32'd302, 0, 0, 1, 20, 20, 2, 0, 0, 0));
      // Release steps that wrap past the top of the step counter.
      send_item(voice_item(2, 0, 32'hFFFF_FFF0, 0, 1, 1, 50, 60, 64, 0, 0, 0));
      send_item(voice_item(2, 0, 32'hFFFF_FFF1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_item(voice_item(2, 1, 32'hFFFF_FFFF, 0, 1, 1, 33, 77, 1, 0, 0, 0));
      send_item(voice_item(2, 1, 32'h0000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      drain_events();

      // Random part: mostly playing on a few tracks, some pure noise.
      song_step = $urandom;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 250 == 249) drain_events();
         if ($urandom_range(0, 9) < 8) begin
            if ($urandom_range(0, 3) == 0) song_step += $urandom_range(1, 3);
            if ($urandom_range(0, 199) == 0) song_step = 32'hFFFF_FFE0 + $urandom_range(0, 16);
            if ($urandom_range(0, 299) == 0) song_step = $urandom;
            item.track           = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                               : 4'($urandom_range(0, 2));
            item.voice_slot      = 2'($urandom_range(0, 3));
            item.cur_step        = song_step;
            item.muted           = ($urandom_range(0, 11) == 0);
            item.trigger_enabled = ($urandom_range(0, 9) != 0);
            item.voice_on        = ($urandom_range(0, 7) != 0);
            item.note            = 7'($urandom_range(0, 127));
            item.velocity        = 7'($urandom_range(0, 127));
            item.length          = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                               : 8'($urandom_range(0, 6));
            item.transpose_offset = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                                : 8'($urandom_range(0, 16) - 8);
            item.velocity_offset  = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                                : 8'($urandom_range(0, 40) - 20);
            item.length_offset    = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                                : 8'($urandom_range(0, 8) - 4);
         end else begin
            noise = {$urandom, $urandom, $urandom};
            item  = noise[$bits(req_type)-1:0];
         end
         send_item(item);
      end

      // Let every predicted event come out, then a short quiet tail.
      drain_events();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_total == 0 && events_outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
